// ----- rtl/cdi_pkg.sv -----
// Shared types, constants and the month length function of the date/day index converter.
`default_nettype none

package cdi_pkg;

   // Day accumulator wide enough for the widest year window.
   localparam int ACC_W = 20;
   localparam int LEN_W = 9;

   localparam logic [LEN_W-1:0] YEAR_DAYS      = 9'd365;
   localparam logic [LEN_W-1:0] LEAP_YEAR_DAYS = 9'd366;
   localparam logic [3:0]       MONTH_FIRST    = 4'd1;
   localparam logic [3:0]       MONTH_LAST     = 4'd12;

   // Operation codes.
   localparam logic OP_DATE_TO_INDEX = 1'b0;
   localparam logic OP_INDEX_TO_DATE = 1'b1;

   // Control for the shared add/subtract/compare unit.
   typedef struct packed {
      logic             sub;
      logic [LEN_W-1:0] operand;
   } alu_ctl_type;

   typedef struct packed {
      logic [ACC_W-1:0] sum;
      logic             ge;
   } alu_res_type;

   // Length of a month; zero for a month code outside 1..12.
   function automatic logic [LEN_W-1:0] cdi_month_days(input logic leap,
                                                       input logic [3:0] month);
      logic [LEN_W-1:0] len;
      unique case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 9'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 9'd30;
         4'd2:    len = leap ? 9'd29 : 9'd28;
         default: len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cdi_req_if.sv -----
// Request channel of the date/day index converter.
`default_nettype none

interface cdi_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [11:0]        year_in;
   logic [3:0]         month_in;
   logic [4:0]         day_in;
   logic signed [16:0] index_in;

   modport source (output valid, output operation, output year_in, output month_in,
                   output day_in, output index_in, input ready);
   modport sink (input valid, input operation, input year_in, input month_in,
                 input day_in, input index_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/cdi_rsp_if.sv -----
// Response channel of the date/day index converter.
`default_nettype none

interface cdi_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [15:0] index_out;
   logic [11:0] year_out;
   logic [3:0]  month_out;
   logic [4:0]  day_out;

   modport source (output valid, output ok, output index_out, output year_out,
                   output month_out, output day_out, input ready);
   modport sink (input valid, input ok, input index_out, input year_out,
                 input month_out, input day_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/calendar_date_day_index_convert_core.sv -----
// Gregorian date <-> day index converter. Day 0 is 1 January of FIRST_YEAR and the
// window ends on 31 December of LAST_YEAR. Operation 0 checks a date and returns its
// day index; operation 1 turns a day index into year, month and day. Invalid input
// gives ok=0 and zero fields. One item is in flight at a time: after a transfer on the
// request side the core steps the years from FIRST_YEAR, checks the date for
// operation 0, steps the months and presents the result; the year and month steps
// share a single add/subtract/compare unit. Inputs rejected up front go straight to
// the result. The request side is ready again once the response transfer completes.
`default_nettype none

module calendar_date_day_index_convert_core #(
   parameter int FIRST_YEAR = 1970,
   parameter int LAST_YEAR  = 2099
) (
   input wire logic clock,
   input wire logic reset,
   cdi_req_if.sink  req_chan,
   cdi_rsp_if.source rsp_chan
);
   import cdi_pkg::*;

   localparam logic [12:0] FIRST_Y  = 13'(FIRST_YEAR);
   localparam logic [12:0] LAST_Y   = 13'(LAST_YEAR);
   localparam logic [1:0]  MOD4_0   = 2'(FIRST_YEAR % 4);
   localparam logic [6:0]  MOD100_0 = 7'(FIRST_YEAR % 100);
   localparam logic [8:0]  MOD400_0 = 9'(FIRST_YEAR % 400);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_YEAR  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_MONTH = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic             op_ff, op_in;
   logic [11:0]      y_ff, y_in;
   logic [3:0]       m_ff, m_in;
   logic [4:0]       d_ff, d_in;
   logic [12:0]      yr_ff, yr_in;
   logic [3:0]       mo_ff, mo_in;
   logic [1:0]       mod4_ff, mod4_in;
   logic [6:0]       mod100_ff, mod100_in;
   logic [8:0]       mod400_ff, mod400_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic        ok_ff, ok_in;
   logic [15:0] idx_ff, idx_in;
   logic [11:0] yo_ff, yo_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  dy_ff, dy_in;

   logic             leap;
   logic [LEN_W-1:0] ylen;
   logic [LEN_W-1:0] mlen;
   logic             req_xfer;
   alu_ctl_type      alu_ctl;
   alu_res_type      alu_res;

   // Leap year of the year counter, from the running remainders.
   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign ylen = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
   assign mlen = cdi_month_days(leap, mo_ff);

   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_DONE);

   cdi_alu u_alu (
      .acc (acc_ff),
      .ctl (alu_ctl),
      .res (alu_res)
   );

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      d_in      = d_ff;
      yr_in     = yr_ff;
      mo_in     = mo_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      acc_in    = acc_ff;
      ok_in     = ok_ff;
      idx_in    = idx_ff;
      yo_in     = yo_ff;
      mon_in    = mon_ff;
      dy_in     = dy_ff;
      alu_ctl.sub     = op_ff;
      alu_ctl.operand = ylen;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in     = req_chan.operation;
               y_in      = req_chan.year_in;
               m_in      = req_chan.month_in;
               d_in      = req_chan.day_in;
               yr_in     = FIRST_Y;
               mo_in     = MONTH_FIRST;
               mod4_in   = MOD4_0;
               mod100_in = MOD100_0;
               mod400_in = MOD400_0;
               acc_in    = (req_chan.operation == OP_INDEX_TO_DATE) ?
                           {{(ACC_W-16){1'b0}}, req_chan.index_in[15:0]} : '0;
               ok_in  = 1'b0;
               idx_in = '0;
               yo_in  = '0;
               mon_in = '0;
               dy_in  = '0;
               if ((req_chan.operation == OP_DATE_TO_INDEX &&
                    ({1'b0, req_chan.year_in} < FIRST_Y ||
                     {1'b0, req_chan.year_in} > LAST_Y)) ||
                   (req_chan.operation == OP_INDEX_TO_DATE && req_chan.index_in[16])) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_YEAR;
               end
            end
         end

         ST_YEAR: begin
            if (op_ff == OP_DATE_TO_INDEX) begin
               if (yr_ff < {1'b0, y_ff}) begin
                  acc_in    = alu_res.sum;
                  yr_in     = yr_ff + 13'd1;
                  mod4_in   = mod4_ff + 2'd1;
                  mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
                  mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
               end else begin
                  state_in = ST_CHECK;
               end
            end else begin
               if (yr_ff > LAST_Y) begin
                  state_in = ST_DONE;
               end else if (alu_res.ge) begin
                  acc_in    = alu_res.sum;
                  yr_in     = yr_ff + 13'd1;
                  mod4_in   = mod4_ff + 2'd1;
                  mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
                  mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
               end else begin
                  state_in = ST_MONTH;
               end
            end
         end

         // Day against the month length; a bad month code has length zero
         ST_CHECK: begin
            if (d_ff == 5'd0 || {4'd0, d_ff} > cdi_month_days(leap, m_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MONTH;
            end
         end

         ST_MONTH: begin
            alu_ctl.operand = mlen;
            if (op_ff == OP_DATE_TO_INDEX) begin
               if (mo_ff < m_ff) begin
                  acc_in = alu_res.sum;
                  mo_in  = mo_ff + 4'd1;
               end else begin
                  // last step adds the day of month minus one
                  alu_ctl.operand = {4'd0, d_ff - 5'd1};
                  ok_in    = 1'b1;
                  idx_in   = alu_res.sum[15:0];
                  state_in = ST_DONE;
               end
            end else begin
               if (mo_ff > MONTH_LAST) begin
                  state_in = ST_DONE;
               end else if (alu_res.ge) begin
                  acc_in = alu_res.sum;
                  mo_in  = mo_ff + 4'd1;
               end else begin
                  ok_in    = 1'b1;
                  yo_in    = yr_ff[11:0];
                  mon_in   = mo_ff;
                  dy_in    = acc_ff[4:0] + 5'd1;
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      y_ff      <= y_in;
      m_ff      <= m_in;
      d_ff      <= d_in;
      yr_ff     <= yr_in;
      mo_ff     <= mo_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      acc_ff    <= acc_in;
      ok_ff     <= ok_in;
      idx_ff    <= idx_in;
      yo_ff     <= yo_in;
      mon_ff    <= mon_in;
      dy_ff     <= dy_in;
   end

   assign rsp_chan.ok        = ok_ff;
   assign rsp_chan.index_out = idx_ff;
   assign rsp_chan.year_out  = yo_ff;
   assign rsp_chan.month_out = mon_ff;
   assign rsp_chan.day_out   = dy_ff;

   // Checks
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("request and response sides open together");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("request accepted while an item is in flight");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ok) |->
         (rsp_chan.index_out == 16'd0 && rsp_chan.year_out == 12'd0 &&
          rsp_chan.month_out == 4'd0 && rsp_chan.day_out == 5'd0))
      else $error("failed result with nonzero fields");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ok && op_ff == OP_INDEX_TO_DATE) |->
         (rsp_chan.month_out >= MONTH_FIRST && rsp_chan.month_out <= MONTH_LAST &&
          rsp_chan.day_out != 5'd0))
      else $error("converted date out of range");

endmodule

`default_nettype wire

// ----- rtl/cdi_alu.sv -----
// Shared add/subtract unit with a compare against the same operand.
`default_nettype none

module cdi_alu (
   input  wire logic [cdi_pkg::ACC_W-1:0] acc,
   input  wire cdi_pkg::alu_ctl_type      ctl,
   output      cdi_pkg::alu_res_type      res
);
   import cdi_pkg::*;

   logic [ACC_W-1:0] opnd;

   assign opnd    = {{(ACC_W-LEN_W){1'b0}}, ctl.operand};
   assign res.sum = ctl.sub ? (acc - opnd) : (acc + opnd);
   assign res.ge  = (acc >= opnd);

endmodule

`default_nettype wire

// ----- verif/tb_calendar_date_day_index_convert_core.sv -----
// Self-checking testbench of the Gregorian date <-> day index converter core.
`default_nettype none

module tb_calendar_date_day_index_convert_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cdi_pkg::*;

   // Calendar window of the block at its default parameters.
   localparam int unsigned FIRST_YEAR   = 1970;
   localparam int unsigned LAST_YEAR    = 2099;
   localparam int unsigned LAST_INDEX   = 47481;
   localparam int          STALL_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 200;
   localparam int          PHASE_ITEMS  = 440;

   typedef struct packed {
      logic               operation;
      logic [11:0]        year_in;
      logic [3:0]         month_in;
      logic [4:0]         day_in;
      logic signed [16:0] index_in;
   } date_request_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] index_out;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
   } date_result_type;

   logic clock;
   logic reset;

   cdi_req_if req_bus ();
   cdi_rsp_if rsp_bus ();

   calendar_date_day_index_convert_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   date_result_type pending_results[$];
   int              mismatches;
   int              results_checked;
   int              results_ok;
   int              date_items;
   int              index_items;
   int              idle_pct;
   int              stall_pct;
   int              quiet_cycles;

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Calendar arithmetic of the predictor
   function automatic bit is_leap_yr(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned year_length(input int unsigned y);
      return is_leap_yr(y) ? 366 : 365;
   endfunction

   function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap_yr(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Expected result of one request; every invalid input gives an all-zero result.
   function automatic date_result_type predict_conversion(input date_request_type r);
      date_result_type res;
      int unsigned     days;
      int unsigned     yr;
      int unsigned     mo;
      res = '0;
      if (r.operation == OP_DATE_TO_INDEX) begin
         if (r.year_in < FIRST_YEAR || r.year_in > LAST_YEAR) return res;
         if (r.month_in < 1 || r.month_in > 12) return res;
         if (r.day_in < 1 || r.day_in > month_length(32'(r.year_in), 32'(r.month_in)))
            return res;
         days = 0;
         for (yr = FIRST_YEAR; yr < r.year_in; yr++) days += year_length(yr);
         for (mo = 1; mo < r.month_in; mo++) days += month_length(32'(r.year_in), mo);
         days += 32'(r.day_in) - 1;
         res.ok = 1'b1;
         res.index_out = days[15:0];
      end else begin
         if (r.index_in[16]) return res;
         days = 32'(r.index_in[15:0]);
         yr = FIRST_YEAR;
         while (yr <= LAST_YEAR && days >= year_length(yr)) begin
            days -= year_length(yr);
            yr++;
         end
         if (yr > LAST_YEAR) return res;
         mo = 1;
         while (mo <= 12 && days >= month_length(yr, mo)) begin
            days -= month_length(yr, mo);
            mo++;
         end
         if (mo > 12) return res;
         res.ok        = 1'b1;
         res.year_out  = yr[11:0];
         res.month_out = mo[3:0];
         res.day_out   = 5'(days + 1);
      end
      return res;
   endfunction

   // Requests with random content in the fields the operation ignores
   function automatic date_request_type date_request(input int unsigned y, input int unsigned m,
                                                     input int unsigned d);
      date_request_type r;
      r.operation = OP_DATE_TO_INDEX;
      r.year_in   = y[11:0];
      r.month_in  = m[3:0];
      r.day_in    = d[4:0];
      r.index_in  = 17'($urandom);
      return r;
   endfunction

   function automatic date_request_type index_request(input int i);
      date_request_type r;
      r.operation = OP_INDEX_TO_DATE;
      r.year_in   = 12'($urandom);
      r.month_in  = 4'($urandom);
      r.day_in    = 5'($urandom);
      r.index_in  = 17'(i);
      return r;
   endfunction

   // Mostly well-formed dates and in-window indexes, the rest noise and near misses
   function automatic date_request_type random_request();
      int unsigned y;
      int unsigned m;
      int unsigned pick;
      pick = $urandom_range(99);
      if ($urandom_range(1) == 0) begin
         y = $urandom_range(LAST_YEAR, FIRST_YEAR);
         m = $urandom_range(12, 1);
         if (pick < 80)
            return date_request(y, m, $urandom_range(month_length(y, m), 1));
         else if (pick < 88)
            return date_request(y, m, month_length(y, m) + 1);
         else
            return date_request($urandom_range(4095), $urandom_range(15), $urandom_range(31));
      end else begin
         if (pick < 80)
            return index_request($urandom_range(LAST_INDEX));
         else if (pick < 90)
            return index_request($urandom_range(65535, LAST_INDEX + 1));
         else
            return index_request(int'($signed(17'($urandom))));
      end
   endfunction

   // Drive one request from a falling edge and hold it until the transfer
   task automatic send_request(input date_request_type r);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.operation = r.operation;
      req_bus.year_in   = r.year_in;
      req_bus.month_in  = r.month_in;
      req_bus.day_in    = r.day_in;
      req_bus.index_in  = r.index_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(predict_conversion(r));
      if (r.operation == OP_DATE_TO_INDEX) date_items++;
      else index_items++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic wait_for_drain();
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);
   end

   function automatic void check_field(input string name, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      date_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
         end else begin
            exp_res = pending_results.pop_front();
            check_field("ok", 32'(exp_res.ok), 32'(rsp_bus.ok));
            check_field("index_out", 32'(exp_res.index_out), 32'(rsp_bus.index_out));
            check_field("year_out", 32'(exp_res.year_out), 32'(rsp_bus.year_out));
            check_field("month_out", 32'(exp_res.month_out), 32'(rsp_bus.month_out));
            check_field("day_out", 32'(exp_res.day_out), 32'(rsp_bus.day_out));
            results_checked++;
            if (exp_res.ok) results_ok++;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
         $display("tb_calendar_date_day_index_convert_core failed");
         $finish;
      end
   end

   // Dates at the window edges, leap days and malformed fields
   task automatic test_date_edges();
      send_request(date_request(FIRST_YEAR, 1, 1));
      send_request(date_request(LAST_YEAR, 12, 31));
      send_request(date_request(2000, 2, 29));      // century leap year
      send_request(date_request(1972, 2, 29));
      send_request(date_request(2096, 2, 29));
      send_request(date_request(1971, 2, 29));      // not a leap year
      send_request(date_request(LAST_YEAR, 2, 29));
      send_request(date_request(FIRST_YEAR - 1, 12, 31));
      send_request(date_request(LAST_YEAR + 1, 1, 1));
      send_request(date_request(0, 0, 0));
      send_request(date_request(4095, 15, 31));
      send_request(date_request(1985, 0, 10));
      send_request(date_request(1985, 13, 10));
      send_request(date_request(1985, 6, 0));
      send_request(date_request(1985, 4, 31));      // past the month length
      send_request(date_request(1985, 12, 31));
   endtask

   // Indexes at the window edges, negative and past the end
   task automatic test_index_edges();
      send_request(index_request(0));
      send_request(index_request(LAST_INDEX));
      send_request(index_request(LAST_INDEX + 1));
      send_request(index_request(65535));
      send_request(index_request(-1));
      send_request(index_request(-65536));
      send_request(index_request(789));             // 29 February 1972
      send_request(index_request(10956));
      send_request(index_request(59));
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int count);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      repeat (count) send_request(random_request());
   endtask

   initial begin
      mismatches      = 0;
      results_checked = 0;
      results_ok      = 0;
      date_items      = 0;
      index_items     = 0;
      quiet_cycles    = 0;
      idle_pct        = 0;
      stall_pct       = 0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_DATE_TO_INDEX;
      req_bus.year_in   = '0;
      req_bus.month_in  = '0;
      req_bus.day_in    = '0;
      req_bus.index_in  = '0;
      rsp_bus.ready     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_date_edges();
      test_index_edges();
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_random_traffic(76, 0, PHASE_ITEMS);
      test_random_traffic(0, 76, PHASE_ITEMS);
      test_random_traffic(18, 18, PHASE_ITEMS);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d date and %0d index requests over four flow patterns",
               date_items, index_items);
      $display("checked %0d results, %0d valid conversions, %0d mismatches",
               results_checked, results_ok, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb_calendar_date_day_index_convert_core passed");
      else
         $display("tb_calendar_date_day_index_convert_core failed");
      $finish;
   end

endmodule

`default_nettype wire
